[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers used by the interpolator core. Under
// synthesis the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk, switched off while arst_n is low.
`define MBI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define MBI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBI_ASSERT(lbl, prop, msg)
`define MBI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/mbi_pkg.sv]
// ----------------------------------------------------------------------------
// mbi_pkg
// Beat layouts, command codes and fixed arithmetic widths of the bilinear
// map interpolator.
// ----------------------------------------------------------------------------
package mbi_pkg;

	typedef enum logic [1:0] {
		CMD_LOOKUP  = 2'd0,
		CMD_WR_CELL = 2'd1,
		CMD_WR_COL  = 2'd2,
		CMD_WR_ROW  = 2'd3
	} cmd_t;

	localparam logic STATUS_LOOKUP = 1'b0;
	localparam logic STATUS_WRITE  = 1'b1;

	localparam int VALUE_W  = 16;
	localparam int COORD_W  = 16;
	// Difference of two unsigned coordinates.
	localparam int DIFF_W   = COORD_W + 1;
	// Product of two differences, magnitude below 2**32.
	localparam int WEIGHT_W = 33;
	// Cell times weight, magnitude at most 2**47.
	localparam int PROD_W   = 48;
	// Sum of four products, room left for negation.
	localparam int NUM_W    = 51;
	// Magnitude of the cell area.
	localparam int DEN_W    = 32;
	// Quotient bits resolved by the divider before saturation.
	localparam int QUOT_W   = 17;

	typedef struct packed {
		cmd_t                 cmd;
		logic [1:0]           map_select;
		logic [3:0]           row_index;
		logic [3:0]           col_index;
		logic [VALUE_W-1:0]   write_value;
		logic [COORD_W-1:0]   x_coord;
		logic [COORD_W-1:0]   y_coord;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] interp_value;
		logic                      status;
	} result_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
	} div_req_t;

	typedef struct packed {
		logic                      done;
		logic signed [VALUE_W-1:0] quot;
	} div_rsp_t;

endpackage

[rtl/mbi_stream_if.sv]
// ----------------------------------------------------------------------------
// mbi_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface mbi_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/mbi_ram.sv]
// ----------------------------------------------------------------------------
// mbi_ram
// Generic RAM with one write port and one read port; read data is
// registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module mbi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

[rtl/mbi_div.sv]
// ----------------------------------------------------------------------------
// mbi_div
// Restoring divider for the blend: floors a signed numerator by a positive
// area, one quotient bit per cycle, and saturates the result to Q8.8.
// ----------------------------------------------------------------------------
module mbi_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mbi_pkg::div_req_t req,
	output mbi_pkg::div_rsp_t rsp
);
	localparam int MAG_W = mbi_pkg::NUM_W;
	localparam int QW    = mbi_pkg::QUOT_W;
	localparam int CNT_W = $clog2(QW);
	localparam int SW    = QW + 2;
	localparam int VW    = mbi_pkg::VALUE_W;

	localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
	localparam logic signed [SW-1:0] SAT_LO = SW'(-32768);
	localparam logic signed [VW-1:0] VAL_HI = VW'(32767);
	localparam logic signed [VW-1:0] VAL_LO = VW'(-32768);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_FIN  = 3'b100
	} dstate_t;

	dstate_t           state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic              over_q;
	logic [MAG_W-1:0]  rem_q;
	logic [MAG_W-1:0]  dsh_q;
	logic [QW-1:0]     quo_q;

	logic signed [MAG_W-1:0] num_s;
	logic [MAG_W-1:0]        mag;
	logic [MAG_W-1:0]        den_top;
	logic                    fits;
	logic [SW-1:0]           q_ext;
	logic [SW-1:0]           q_up;
	logic signed [SW-1:0]    sval;
	logic signed [VW-1:0]    sat_val;

	assign num_s   = $signed(req.num);
	assign mag     = num_s[MAG_W-1] ? MAG_W'(-num_s) : MAG_W'(num_s);
	// A quotient of 2**17 or more saturates whatever its sign.
	assign den_top = MAG_W'(req.den) << QW;
	assign fits    = rem_q >= dsh_q;

	// Floor: a negative quotient with a remainder rounds one step further down.
	assign q_ext = SW'(quo_q);
	assign q_up  = q_ext + SW'(rem_q != '0);
	assign sval  = neg_q ? -$signed(q_up) : $signed(q_ext);

	always_comb begin
		if (over_q) begin
			sat_val = neg_q ? VAL_LO : VAL_HI;
		end else if (sval > SAT_HI) begin
			sat_val = VAL_HI;
		end else if (sval < SAT_LO) begin
			sat_val = VAL_LO;
		end else begin
			sat_val = VW'(sval);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						cnt_q   <= CNT_W'(QW - 1);
						state_q <= (mag >= den_top) ? D_FIN : D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && req.start) begin
			neg_q  <= num_s[MAG_W-1];
			over_q <= mag >= den_top;
			rem_q  <= mag;
			dsh_q  <= MAG_W'(req.den) << (QW - 1);
			quo_q  <= '0;
		end else if (state_q == D_RUN) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QW-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done = state_q == D_FIN;
	assign rsp.quot = sat_val;
endmodule

[rtl/map_bilinear_interpolator_core.sv]
// ----------------------------------------------------------------------------
// map_bilinear_interpolator_core
// Writes and missing-map lookups are acknowledged via the output register once
// it is free, waiting in S_DONE while it is busy. A lookup passes the clamp, the
// breakpoint scan (one axis RAM read per cycle), the neighbour reads, the blend
// and the divider; one item is in flight at a time. arst_n clears control.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module map_bilinear_interpolator_core #(
	parameter int GRID_COLS = 16,
	parameter int GRID_ROWS = 16,
	parameter int NUM_MAPS  = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	mbi_stream_if.sink   item,
	mbi_stream_if.source result
);
	localparam int CELL_COUNT = NUM_MAPS * GRID_ROWS * GRID_COLS;
	localparam int CELL_AW    = $clog2(CELL_COUNT);
	localparam int COL_AW     = $clog2(GRID_COLS);
	localparam int ROW_AW     = $clog2(GRID_ROWS);
	localparam int MAX_LEN    = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
	localparam int KW         = $clog2(MAX_LEN);
	localparam int SCAN_LAST  = MAX_LEN - 2;
	localparam int VW         = mbi_pkg::VALUE_W;
	localparam int CW         = mbi_pkg::COORD_W;
	localparam int DW         = mbi_pkg::DIFF_W;
	localparam int WW         = mbi_pkg::WEIGHT_W;
	localparam int PW         = mbi_pkg::PROD_W;
	localparam int NW         = mbi_pkg::NUM_W;
	localparam int DENW       = mbi_pkg::DEN_W;
	localparam logic [2:0] MAC_LAST = 3'd6;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_LO   = 13'b0000000000010,
		S_HI   = 13'b0000000000100,
		S_CLMP = 13'b0000000001000,
		S_SCAN = 13'b0000000010000,
		S_NB0  = 13'b0000000100000,
		S_NB1  = 13'b0000001000000,
		S_NB2  = 13'b0000010000000,
		S_NB3  = 13'b0000100000000,
		S_MAC  = 13'b0001000000000,
		S_FIX  = 13'b0010000000000,
		S_DIV  = 13'b0100000000000,
		S_DONE = 13'b1000000000000
	} state_t;

	function automatic logic [CELL_AW-1:0] cell_addr_f(
		input int unsigned m,
		input int unsigned r,
		input int unsigned c
	);
		return CELL_AW'((m * GRID_ROWS + r) * GRID_COLS + c);
	endfunction

	// Control state
	state_t           state_q;
	logic [KW-1:0]    k_q;
	logic             cfound_q;
	logic             rfound_q;
	logic [COL_AW-1:0] ci_q;
	logic [ROW_AW-1:0] ri_q;
	logic [2:0]       mac_q;
	logic             out_v_q;

	// Payload
	logic [1:0]              map_q;
	logic [CW-1:0]           xc_q;
	logic [CW-1:0]           yc_q;
	logic [CW-1:0]           x1_q;
	logic [CW-1:0]           x2_q;
	logic [CW-1:0]           y1_q;
	logic [CW-1:0]           y2_q;
	logic signed [VW-1:0]    q11_q;
	logic signed [VW-1:0]    q21_q;
	logic signed [VW-1:0]    q12_q;
	logic signed [VW-1:0]    q22_q;
	logic signed [WW-1:0]    w_q;
	logic signed [WW-1:0]    area_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [NW-1:0]    acc_q;
	mbi_pkg::result_t        res_q;
	mbi_pkg::result_t        out_data_q;

	mbi_pkg::item_t   itm;
	mbi_pkg::result_t imm_res;
	logic             accept;
	logic             map_ok;
	logic             starts_lookup;
	logic             out_free;

	logic              cell_we;
	logic [CELL_AW-1:0] cell_waddr;
	logic [CELL_AW-1:0] cell_raddr;
	logic [VW-1:0]     cell_rdata;
	logic              col_we;
	logic [COL_AW-1:0] col_raddr;
	logic [CW-1:0]     col_rdata;
	logic              row_we;
	logic [ROW_AW-1:0] row_raddr;
	logic [CW-1:0]     row_rdata;

	logic [KW-1:0]     k_nxt;
	logic [COL_AW-1:0] col_scan_addr;
	logic [ROW_AW-1:0] row_scan_addr;
	logic              col_hit;
	logic              row_hit;
	logic [COL_AW-1:0] ci_eff;
	logic [COL_AW-1:0] ci_lo;
	logic [ROW_AW-1:0] ri_eff;
	logic [ROW_AW-1:0] ri_lo;

	logic signed [DW-1:0]   dxa;
	logic signed [DW-1:0]   dya;
	logic signed [DW-1:0]   dx1;
	logic signed [DW-1:0]   dx2;
	logic signed [DW-1:0]   dy1;
	logic signed [DW-1:0]   dy2;
	logic signed [DW-1:0]   op_a;
	logic signed [DW-1:0]   op_b;
	logic signed [2*DW-1:0] w_full;
	logic signed [VW-1:0]   q_sel;
	logic signed [VW+WW-1:0] p_full;

	logic              area_zero;
	logic              area_neg;
	mbi_pkg::div_req_t div_req;
	mbi_pkg::div_rsp_t div_rsp;

	// ------------------------------------------------------------------
	// Input beat decode
	// ------------------------------------------------------------------
	assign itm           = item.data;
	assign item.ready    = state_q == S_IDLE;
	assign accept        = item.valid && item.ready;
	assign map_ok        = int'(itm.map_select) < NUM_MAPS;
	assign starts_lookup = (itm.cmd == mbi_pkg::CMD_LOOKUP) && map_ok;
	assign out_free      = !out_v_q || result.ready;

	// Writes and lookups of a missing map are answered without a lookup, with a zero value.
	assign imm_res.interp_value = '0;
	assign imm_res.status       = (itm.cmd == mbi_pkg::CMD_LOOKUP) ?
		mbi_pkg::STATUS_LOOKUP : mbi_pkg::STATUS_WRITE;

	// Writes land only while idle, so no lookup read can overlap them.
	assign cell_we    = accept && (itm.cmd == mbi_pkg::CMD_WR_CELL) && map_ok &&
		(int'(itm.row_index) < GRID_ROWS) && (int'(itm.col_index) < GRID_COLS);
	assign cell_waddr = cell_addr_f(int'(itm.map_select), int'(itm.row_index),
		int'(itm.col_index));
	assign col_we     = accept && (itm.cmd == mbi_pkg::CMD_WR_COL) &&
		(int'(itm.col_index) < GRID_COLS);
	assign row_we     = accept && (itm.cmd == mbi_pkg::CMD_WR_ROW) &&
		(int'(itm.row_index) < GRID_ROWS);

	// ------------------------------------------------------------------
	// Storage
	// ------------------------------------------------------------------
	mbi_ram #(.WIDTH(VW), .DEPTH(CELL_COUNT)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (itm.write_value),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	mbi_ram #(.WIDTH(CW), .DEPTH(GRID_COLS)) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (COL_AW'(itm.col_index)),
		.wdata (itm.write_value),
		.raddr (col_raddr),
		.rdata (col_rdata)
	);

	mbi_ram #(.WIDTH(CW), .DEPTH(GRID_ROWS)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (ROW_AW'(itm.row_index)),
		.wdata (itm.write_value),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	// ------------------------------------------------------------------
	// Axis scan addressing
	// ------------------------------------------------------------------
	assign k_nxt = k_q + KW'(1);

	// The shorter axis parks on its last entry once its scan is over.
	assign col_scan_addr = (int'(k_nxt) > GRID_COLS - 1) ? COL_AW'(GRID_COLS - 1) :
		COL_AW'(k_nxt);
	assign row_scan_addr = (int'(k_nxt) > GRID_ROWS - 1) ? ROW_AW'(GRID_ROWS - 1) :
		ROW_AW'(k_nxt);

	// The data in the scan state belongs to breakpoint k_q.
	assign col_hit = !cfound_q && (int'(k_q) <= GRID_COLS - 2) && (col_rdata >= xc_q);
	assign row_hit = !rfound_q && (int'(k_q) <= GRID_ROWS - 2) && (row_rdata >= yc_q);

	assign ci_eff = (ci_q == '0) ? COL_AW'(1) : ci_q;
	assign ci_lo  = ci_eff - COL_AW'(1);
	assign ri_eff = (ri_q == '0) ? ROW_AW'(1) : ri_q;
	assign ri_lo  = ri_eff - ROW_AW'(1);

	always_comb begin
		col_raddr  = '0;
		row_raddr  = '0;
		cell_raddr = '0;
		unique case (state_q)
			S_HI: begin
				col_raddr = COL_AW'(GRID_COLS - 1);
				row_raddr = ROW_AW'(GRID_ROWS - 1);
			end
			S_SCAN: begin
				col_raddr = col_scan_addr;
				row_raddr = row_scan_addr;
			end
			S_NB0: begin
				col_raddr  = ci_lo;
				row_raddr  = ri_lo;
				cell_raddr = cell_addr_f(int'(map_q), int'(ri_lo), int'(ci_lo));
			end
			S_NB1: begin
				col_raddr  = ci_eff;
				row_raddr  = ri_eff;
				cell_raddr = cell_addr_f(int'(map_q), int'(ri_lo), int'(ci_eff));
			end
			S_NB2: begin
				cell_raddr = cell_addr_f(int'(map_q), int'(ri_eff), int'(ci_lo));
			end
			S_NB3: begin
				cell_raddr = cell_addr_f(int'(map_q), int'(ri_eff), int'(ci_eff));
			end
			default: begin
				col_raddr  = '0;
				row_raddr  = '0;
				cell_raddr = '0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Blend datapath: one weight product and one cell product per cycle
	// ------------------------------------------------------------------
	assign dxa = $signed({1'b0, x2_q}) - $signed({1'b0, x1_q});
	assign dya = $signed({1'b0, y2_q}) - $signed({1'b0, y1_q});
	assign dx1 = $signed({1'b0, xc_q}) - $signed({1'b0, x1_q});
	assign dx2 = $signed({1'b0, x2_q}) - $signed({1'b0, xc_q});
	assign dy1 = $signed({1'b0, yc_q}) - $signed({1'b0, y1_q});
	assign dy2 = $signed({1'b0, y2_q}) - $signed({1'b0, yc_q});

	// Step 0 forms the cell area, steps 1 to 4 the weights of q11, q21, q12, q22.
	always_comb begin
		case (mac_q)
			3'd0: begin
				op_a = dxa;
				op_b = dya;
			end
			3'd1: begin
				op_a = dx2;
				op_b = dy2;
			end
			3'd2: begin
				op_a = dx1;
				op_b = dy2;
			end
			3'd3: begin
				op_a = dx2;
				op_b = dy1;
			end
			3'd4: begin
				op_a = dx1;
				op_b = dy1;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		case (mac_q)
			3'd2:    q_sel = q11_q;
			3'd3:    q_sel = q21_q;
			3'd4:    q_sel = q12_q;
			3'd5:    q_sel = q22_q;
			default: q_sel = '0;
		endcase
	end

	assign w_full = op_a * op_b;
	assign p_full = q_sel * w_q;

	assign area_zero = area_q == '0;
	assign area_neg  = area_q[WW-1];

	always_comb begin
		div_req.start = (state_q == S_FIX) && !area_zero;
		div_req.num   = area_neg ? -acc_q : acc_q;
		div_req.den   = area_neg ? DENW'(-area_q) : DENW'(area_q);
	end

	mbi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			k_q      <= '0;
			cfound_q <= 1'b0;
			rfound_q <= 1'b0;
			ci_q     <= '0;
			ri_q     <= '0;
			mac_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (starts_lookup) begin
							state_q <= S_LO;
						end else if (!out_free) begin
							state_q <= S_DONE;
						end
					end
				end
				S_LO: begin
					state_q <= S_HI;
				end
				S_HI: begin
					state_q <= S_CLMP;
				end
				S_CLMP: begin
					k_q      <= '0;
					cfound_q <= 1'b0;
					rfound_q <= 1'b0;
					ci_q     <= COL_AW'(GRID_COLS - 1);
					ri_q     <= ROW_AW'(GRID_ROWS - 1);
					state_q  <= S_SCAN;
				end
				S_SCAN: begin
					if (col_hit) begin
						cfound_q <= 1'b1;
						ci_q     <= COL_AW'(k_q);
					end
					if (row_hit) begin
						rfound_q <= 1'b1;
						ri_q     <= ROW_AW'(k_q);
					end
					k_q <= k_nxt;
					if (k_q == KW'(SCAN_LAST)) begin
						state_q <= S_NB0;
					end
				end
				S_NB0: begin
					state_q <= S_NB1;
				end
				S_NB1: begin
					state_q <= S_NB2;
				end
				S_NB2: begin
					state_q <= S_NB3;
				end
				S_NB3: begin
					mac_q   <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					mac_q <= mac_q + 3'd1;
					if (mac_q == MAC_LAST) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					state_q <= area_zero ? S_DONE : S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				map_q <= itm.map_select;
				xc_q  <= itm.x_coord;
				yc_q  <= itm.y_coord;
				res_q <= imm_res;
			end
			S_HI: begin
				// Breakpoint 0 arrives: raise the coordinates to the axis start.
				if (xc_q < col_rdata) begin
					xc_q <= col_rdata;
				end
				if (yc_q < row_rdata) begin
					yc_q <= row_rdata;
				end
			end
			S_CLMP: begin
				// Last breakpoint arrives: lower the coordinates to the axis end.
				if (xc_q > col_rdata) begin
					xc_q <= col_rdata;
				end
				if (yc_q > row_rdata) begin
					yc_q <= row_rdata;
				end
			end
			S_NB1: begin
				x1_q  <= col_rdata;
				y1_q  <= row_rdata;
				q11_q <= $signed(cell_rdata);
			end
			S_NB2: begin
				x2_q  <= col_rdata;
				y2_q  <= row_rdata;
				q21_q <= $signed(cell_rdata);
			end
			S_NB3: begin
				q12_q <= $signed(cell_rdata);
			end
			S_MAC: begin
				if (mac_q == 3'd0) begin
					q22_q <= $signed(cell_rdata);
					acc_q <= '0;
				end
				if (mac_q <= 3'd4) begin
					w_q <= WW'(w_full);
				end
				if (mac_q == 3'd1) begin
					area_q <= w_q;
				end
				if (mac_q >= 3'd2 && mac_q <= 3'd5) begin
					prod_q <= PW'(p_full);
				end
				if (mac_q >= 3'd3) begin
					acc_q <= acc_q + NW'(prod_q);
				end
			end
			S_FIX: begin
				// A degenerate cell returns its lower-left corner unchanged.
				res_q.interp_value <= q11_q;
				res_q.status       <= mbi_pkg::STATUS_LOOKUP;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					res_q.interp_value <= div_rsp.quot;
					res_q.status       <= mbi_pkg::STATUS_LOOKUP;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((accept && !starts_lookup && out_free) ||
			(state_q == S_DONE && out_free)) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !starts_lookup && out_free) begin
			out_data_q <= imm_res;
		end else if (state_q == S_DONE && out_free) begin
			out_data_q <= res_q;
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = out_data_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`MBI_ASSERT(a_accept_effect, accept |=> (state_q != S_IDLE) || out_v_q, "accepted beat was dropped")
	`MBI_ASSERT(a_div_done_wait, div_rsp.done |-> state_q == S_DIV, "divider finished outside its wait state")
	`MBI_ASSERT(a_done_drain, (state_q == S_DONE) && out_free |=> out_v_q && (state_q == S_IDLE), "pending result not moved to output")
	`MBI_ASSERT_ALWAYS(a_div_idle_reset, !arst_n |=> !div_req.start, "divider started during reset")
endmodule
